[rtl/crcdf_pkg.sv]
// crcdf_pkg: types, codes and the byte-wide crc-32 update shared by the record deframer.
// no dependencies; imported by every module of the deframer.
`timescale 1ns / 1ps

package crcdf_pkg;

   localparam logic [31:0] MAGIC_WORD      = 32'hB0DE744C;
   localparam logic [31:0] MIN_RECORD_SIZE = 32'd14;
   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_START_OF_FILE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_CLOCK_SYNC    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_PERIODIC_DATA = 2'd2;

   // record end status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_BAD_MAGIC  = 3'd1;
   localparam logic [2:0] STATUS_UNKNOWN    = 3'd2;
   localparam logic [2:0] STATUS_CRC_BAD    = 3'd3;
   localparam logic [2:0] STATUS_SIZE_SMALL = 3'd4;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd5;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_SIZE,
      PH_TYPE,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [15:0] record_kind;
      logic [2:0]  status;
   } result_type;

   // everything one input word causes: an optional parse result and an optional truncation
   typedef struct packed {
      logic        prim_valid;
      result_type  prim;
      logic        trunc_valid;
      logic [15:0] trunc_kind;
   } entry_type;

   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

[rtl/crc32_record_deframer_unit.sv]
// crc32_record_deframer_unit: top level of the crc-32 checked record deframer.
// instantiates crcdf_front, crcdf_queue and crcdf_back; depends on crcdf_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata[7:0] in_byte, tlast stream_end
//   rsp      out        rsp_tvalid/rsp_tready  tdata payload_byte/record_kind/status,
//                                              tuser kind, tlast run_last
//   csr      in         csr_we                 csr_index, csr_wdata (type codes)
//
// one byte word is taken per cycle while the queue has room; crc update and field parsing happen
// in the same front cycle. results leave one per cycle while rsp_tready is high; a byte with two
// results (a truncation) holds the output for both. the entry queue (QUEUE_DEPTH) parts req_tready
// from rsp_tready; req stalls only when it is full. synchronous reset, no clearing pass.
`timescale 1ns / 1ps

module crc32_record_deframer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [crcdf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [crcdf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] in_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] payload_byte, [23:8] record_kind, [26:24] status, [31:27] zero
   output logic [crcdf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tuser,   // [0] kind
   output logic                               rsp_tlast
);
   import crcdf_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   crcdf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .queue_ready (push_ready),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   crcdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   crcdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/crcdf_front.sv]
// crcdf_front: record parser; takes one byte word per cycle while the queue has room, tracks
// magic/size/type/payload/crc fields, emits one entry per word with results. depends on crcdf_pkg.
`timescale 1ns / 1ps

module crcdf_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [crcdf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [crcdf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   input  logic                               req_tlast,
   input  logic                               queue_ready,
   output logic                               push_valid,
   output crcdf_pkg::entry_type               push_entry
);
   import crcdf_pkg::*;

   logic [15:0] code_sof_ff, code_sync_ff, code_periodic_ff;

   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] remain_ff, remain_in;
   logic [15:0] type_ff, type_in;
   logic [31:0] crc_ff, crc_in;

   logic        fire;
   logic [31:0] shifted;
   logic [1:0]  idx_inc;
   logic [31:0] crc_upd;
   logic [15:0] new_type;
   logic        type_known;
   logic        restart;

   assign req_tready = queue_ready;
   assign fire       = req_tvalid && queue_ready;

   assign shifted  = {req_tdata, shift_ff[31:8]};
   assign idx_inc  = idx_ff + 2'd1;
   assign crc_upd  = crc_step(crc_ff, req_tdata);
   assign new_type = shifted[31:16];
   assign type_known = (new_type == code_sof_ff) || (new_type == code_sync_ff) ||
                       (new_type == code_periodic_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_sof_ff      <= 16'd1;
         code_sync_ff     <= 16'd2;
         code_periodic_ff <= 16'd3;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CODE_START_OF_FILE: code_sof_ff      <= csr_wdata;
            CSR_CODE_CLOCK_SYNC:    code_sync_ff     <= csr_wdata;
            CSR_CODE_PERIODIC_DATA: code_periodic_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         idx_ff    <= 2'd0;
         shift_ff  <= 32'd0;
         remain_ff <= 32'd0;
         type_ff   <= 16'd0;
         crc_ff    <= CRC_INIT;
      end else if (fire) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         shift_ff  <= shift_in;
         remain_ff <= remain_in;
         type_ff   <= type_in;
         crc_ff    <= crc_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      remain_in = remain_ff;
      type_in   = type_ff;
      crc_in    = crc_ff;
      restart   = 1'b0;
      push_entry = '0;

      case (phase_ff)
         PH_MAGIC: begin
            crc_in   = crc_upd;
            shift_in = shifted;
            idx_in   = idx_inc;
            if (idx_inc == 2'd0) begin
               if (shifted != MAGIC_WORD) begin
                  push_entry.prim_valid = 1'b1;
                  push_entry.prim = '{KIND_STATUS, 8'd0, 16'd0, STATUS_BAD_MAGIC};
                  restart = 1'b1;
               end else begin
                  shift_in = 32'd0;
                  phase_in = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            crc_in   = crc_upd;
            shift_in = shifted;
            idx_in   = idx_inc;
            if (idx_inc == 2'd0) begin
               if (shifted < MIN_RECORD_SIZE) begin
                  push_entry.prim_valid = 1'b1;
                  push_entry.prim = '{KIND_STATUS, 8'd0, 16'd0, STATUS_SIZE_SMALL};
                  restart = 1'b1;
               end else begin
                  remain_in = shifted - MIN_RECORD_SIZE;
                  shift_in  = 32'd0;
                  phase_in  = PH_TYPE;
               end
            end
         end
         PH_TYPE: begin
            crc_in   = crc_upd;
            shift_in = shifted;
            idx_in   = idx_inc;
            if (idx_inc == 2'd2) begin
               type_in  = new_type;
               shift_in = 32'd0;
               idx_in   = 2'd0;
               if (!type_known) begin
                  push_entry.prim_valid = 1'b1;
                  push_entry.prim = '{KIND_STATUS, 8'd0, new_type, STATUS_UNKNOWN};
                  restart = 1'b1;
               end else begin
                  phase_in = (remain_ff != 32'd0) ? PH_PAYLOAD : PH_CRC;
               end
            end
         end
         PH_PAYLOAD: begin
            crc_in    = crc_upd;
            remain_in = remain_ff - 32'd1;
            push_entry.prim_valid = 1'b1;
            push_entry.prim = '{KIND_PAYLOAD, req_tdata, type_ff, STATUS_OK};
            if (remain_ff == 32'd1) begin
               phase_in = PH_CRC;
               idx_in   = 2'd0;
               shift_in = 32'd0;
            end
         end
         PH_CRC: begin
            shift_in = shifted;
            idx_in   = idx_inc;
            if (idx_inc == 2'd0) begin
               push_entry.prim_valid = 1'b1;
               push_entry.prim = '{KIND_STATUS, 8'd0, type_ff,
                                   (shifted == ~crc_ff) ? STATUS_OK : STATUS_CRC_BAD};
               restart = 1'b1;
            end
         end
         default: restart = 1'b1;
      endcase

      if (restart) begin
         phase_in  = PH_MAGIC;
         idx_in    = 2'd0;
         shift_in  = 32'd0;
         remain_in = 32'd0;
         type_in   = 16'd0;
         crc_in    = CRC_INIT;
      end

      // stream ends anywhere but on a record boundary
      if (req_tlast && !(phase_in == PH_MAGIC && idx_in == 2'd0)) begin
         push_entry.trunc_valid = 1'b1;
         push_entry.trunc_kind  = type_in;
         phase_in  = PH_MAGIC;
         idx_in    = 2'd0;
         shift_in  = 32'd0;
         remain_in = 32'd0;
         type_in   = 16'd0;
         crc_in    = CRC_INIT;
      end

      push_valid = fire && (push_entry.prim_valid || push_entry.trunc_valid);
   end

endmodule

[rtl/crcdf_queue.sv]
// crcdf_queue: short register queue of result entries between parser and output stage.
// depends on crcdf_pkg for the entry type.
`timescale 1ns / 1ps

module crcdf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  crcdf_pkg::entry_type  push_entry,
   output logic                  push_ready,
   output logic                  pop_valid,
   output crcdf_pkg::entry_type  pop_entry,
   input  logic                  pop_ready
);
   import crcdf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/crcdf_back.sv]
// crcdf_back: output stage; takes queue entries and sends their one or two results as words.
// depends on crcdf_pkg.
`timescale 1ns / 1ps

module crcdf_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   input  crcdf_pkg::entry_type                pop_entry,
   output logic                                pop_ready,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [crcdf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import crcdf_pkg::*;

   entry_type  ent_ff, ent_in;
   logic       valid_ff, valid_in;
   logic       second_ff, second_in;   // set while the truncation result is on the port
   result_type cur;
   logic       fire, done;

   always_comb begin
      if (second_ff) begin
         cur = '{KIND_STATUS, 8'd0, ent_ff.trunc_kind, STATUS_TRUNCATED};
      end else begin
         cur = ent_ff.prim;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = second_ff || !ent_ff.trunc_valid;
   assign rsp_tuser  = cur.kind;
   assign rsp_tdata  = {(RSP_DATA_W - 27)'(0), cur.status, cur.record_kind, cur.payload_byte};

   assign fire      = valid_ff && rsp_tready;
   assign done      = fire && rsp_tlast;
   assign pop_ready = !valid_ff || done;

   always_comb begin
      ent_in    = ent_ff;
      valid_in  = valid_ff;
      second_in = second_ff;
      if (pop_ready) begin
         valid_in = pop_valid;
         if (pop_valid) begin
            ent_in    = pop_entry;
            second_in = !pop_entry.prim_valid;
         end
      end else if (fire) begin
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule
